@@ rtl/core/tpag_pkg.sv @@
// Shared types and constants for the task peripheral actuation guard.
package tpag_pkg;

  localparam int ID_W       = 32;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 3;
  localparam int PERIPH_MAX = 4;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_DONE   = 2'd2,
    MODE_CHECK  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_UNINIT = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_MAX_ACT    = 2'd0,
    CFG_LEFT_OP    = 2'd1,
    CFG_RIGHT_OP   = 2'd2,
    CFG_SAFE_SPEED = 2'd3
  } cfg_idx_t;

  localparam logic [BYTE_W-1:0] MAX_ACT_RST    = 8'd10;
  localparam logic [BYTE_W-1:0] LEFT_OP_RST    = 8'd1;
  localparam logic [BYTE_W-1:0] RIGHT_OP_RST   = 8'd2;
  localparam logic [BYTE_W-1:0] SAFE_SPEED_RST = 8'd0;

  typedef struct packed {
    logic load;
    logic match;
    logic sel;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/core/tpag_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tpag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/tpag_ctrl.sv @@
// Sequencer: accept, tag match, slot select with row read, execute.
module tpag_ctrl import tpag_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_MATCH, S_SEL, S_EXEC} state_t;

  state_t state;

  always_comb begin
    cmd.load  = in_valid && in_ready;
    cmd.match = (state == S_MATCH);
    cmd.sel   = (state == S_SEL);
    cmd.exec  = (state == S_EXEC) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= S_MATCH;
            in_ready <= 1'b0;
          end
        end
        S_MATCH: state <= S_SEL;
        S_SEL:   state <= S_EXEC;
        S_EXEC: begin
          if (stat.out_free) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/tpag_dp.sv @@
// Datapath: config registers, task tag store, slot row RAM, result register.
module tpag_dp import tpag_pkg::*; #(
  parameter int TASK_SLOTS   = 8,
  parameter int PERIPH_SLOTS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  output dp_stat_t          stat,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [BYTE_W-1:0] cfg_wdata,
  input  logic [1:0]        mode,
  input  logic [ID_W-1:0]   task_id,
  input  logic [CNT_W-1:0]  periph_count,
  input  logic [BYTE_W-1:0] allowed [PERIPH_MAX],
  input  logic [BYTE_W-1:0] requested_periph,
  input  logic [BYTE_W-1:0] command_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic              access_ok,
  output logic              force_speed,
  output logic [BYTE_W-1:0] speed_value
);

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int LANE_W = PERIPH_SLOTS * BYTE_W;
  localparam int ROW_W  = CNT_W + 2 * LANE_W;

  // configuration
  logic [BYTE_W-1:0] max_act, left_op, right_op, safe_speed;

  // captured item
  mode_t             mode_q;
  logic [ID_W-1:0]   id_q;
  logic [CNT_W-1:0]  pcount_q;
  logic [BYTE_W-1:0] allowed_q [PERIPH_SLOTS];
  logic [BYTE_W-1:0] req_q, cmd_q;

  // tag store
  logic [TASK_SLOTS-1:0] slot_valid;
  logic [ID_W-1:0]       slot_task [TASK_SLOTS];
  logic                  initialized;

  logic [TASK_SLOTS-1:0] hit_vec, free_vec;
  logic [SLOT_W-1:0]     hit_idx, free_idx, sel_idx, slot_q;
  logic                  hit_q, free_q;

  logic [ROW_W-1:0] rdata, wrow;
  logic             ram_we;

  logic [CNT_W-1:0]  eff_pcount, rd_cnt;
  logic [1:0]        res_status;
  logic              res_ok, res_force;
  logic [BYTE_W-1:0] res_speed;
  logic              set_valid, clr_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_act    <= MAX_ACT_RST;
      left_op    <= LEFT_OP_RST;
      right_op   <= RIGHT_OP_RST;
      safe_speed <= SAFE_SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_ACT:    max_act    <= cfg_wdata;
        CFG_LEFT_OP:    left_op    <= cfg_wdata;
        CFG_RIGHT_OP:   right_op   <= cfg_wdata;
        CFG_SAFE_SPEED: safe_speed <= cfg_wdata;
        default:        max_act    <= max_act;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q   <= mode_t'(mode);
      id_q     <= task_id;
      pcount_q <= periph_count;
      req_q    <= requested_periph;
      cmd_q    <= command_code;
      for (int j = 0; j < PERIPH_SLOTS; j++) begin
        allowed_q[j] <= allowed[j];
      end
    end
  end

  // parallel tag compare
  always_ff @(posedge clk) begin
    if (cmd.match) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        hit_vec[i]  <= slot_valid[i] && (slot_task[i] == id_q);
        free_vec[i] <= !slot_valid[i];
      end
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = SLOT_W'(i);
      end
      if (free_vec[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
    sel_idx = (|hit_vec) ? hit_idx : free_idx;
  end

  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      slot_q <= sel_idx;
      hit_q  <= |hit_vec;
      free_q <= |free_vec;
    end
  end

  // row: {count, allowed lanes, counter lanes}
  tpag_ram #(
    .WIDTH(ROW_W),
    .DEPTH(TASK_SLOTS)
  ) u_rows (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_q),
    .wdata(wrow),
    .re   (cmd.sel),
    .raddr(sel_idx),
    .rdata(rdata)
  );

  assign rd_cnt     = rdata[ROW_W-1 -: CNT_W];
  assign eff_pcount = (pcount_q > CNT_W'(PERIPH_SLOTS)) ? CNT_W'(PERIPH_SLOTS) : pcount_q;

  always_comb begin
    logic              found;
    logic [BYTE_W-1:0] ctr, cnew;
    res_status = STAT_OK;
    res_ok     = 1'b0;
    res_force  = 1'b0;
    res_speed  = '0;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    ram_we     = 1'b0;
    wrow       = rdata;
    found      = 1'b0;
    ctr        = '0;
    cnew       = '0;
    if (mode_q == MODE_ADD) begin
      if (hit_q || free_q) begin
        set_valid = 1'b1;
        ram_we    = 1'b1;
        wrow[ROW_W-1 -: CNT_W] = eff_pcount;
        for (int j = 0; j < PERIPH_SLOTS; j++) begin
          wrow[LANE_W + j*BYTE_W +: BYTE_W] = allowed_q[j];
          wrow[j*BYTE_W +: BYTE_W]          = '0;
        end
      end else begin
        res_status = STAT_FULL;
      end
    end else if (!initialized) begin
      res_status = STAT_UNINIT;
    end else begin
      unique case (mode_q)
        MODE_REMOVE: clr_valid = hit_q;
        MODE_DONE: begin
          ram_we = hit_q;
          for (int j = 0; j < PERIPH_SLOTS; j++) begin
            if (CNT_W'(j) < rd_cnt) begin
              wrow[j*BYTE_W +: BYTE_W] = '0;
            end
          end
        end
        MODE_CHECK: begin
          for (int j = 0; j < PERIPH_SLOTS; j++) begin
            if (!found && (CNT_W'(j) < rd_cnt) &&
                (rdata[LANE_W + j*BYTE_W +: BYTE_W] == req_q)) begin
              found = 1'b1;
              ctr   = rdata[j*BYTE_W +: BYTE_W];
              cnew  = (ctr == '1) ? ctr : ctr + 1'b1;
              wrow[j*BYTE_W +: BYTE_W] = cnew;
            end
          end
          if (hit_q && found) begin
            ram_we = 1'b1;
            if (cnew <= max_act) begin
              res_ok = 1'b1;
            end else if (({1'b0, cnew} == ({1'b0, max_act} + 9'd1)) &&
                         ((cmd_q == left_op) || (cmd_q == right_op))) begin
              res_ok    = 1'b1;
              res_force = 1'b1;
              res_speed = safe_speed;
            end
          end
        end
        default: res_status = STAT_OK;
      endcase
    end
    ram_we = ram_we && cmd.exec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= '0;
      initialized <= 1'b0;
    end else if (cmd.exec) begin
      if (set_valid) begin
        slot_valid[slot_q] <= 1'b1;
        initialized        <= 1'b1;
      end else if (clr_valid) begin
        slot_valid[slot_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && set_valid) begin
      slot_task[slot_q] <= id_q;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status      <= res_status;
      access_ok   <= res_ok;
      force_speed <= res_force;
      speed_value <= res_speed;
    end
  end

endmodule

@@ rtl/core/task_peripheral_actuation_guard.sv @@
// Task peripheral actuation guard: an item is accepted, its task id is compared
// against all task slots in parallel, the matching (or first free) slot is
// encoded and its row of allowed peripherals and actuation counters is read
// from the slot RAM, and in the execute state the row is updated and the result
// beat is registered. The input reopens at the same edge that loads the result,
// so one item is in flight at a time and a new item is accepted only after the
// last one completes; the tag compare, slot encode with RAM read, and
// read-modify-write of the row are sequential steps.
// A pending result does not block the next acceptance, only its completion.
module task_peripheral_actuation_guard import tpag_pkg::*; #(
  parameter int TASK_SLOTS   = 8,
  parameter int PERIPH_SLOTS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [BYTE_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        mode,
  input  logic [ID_W-1:0]   task_id,
  input  logic [CNT_W-1:0]  periph_count,
  input  logic [BYTE_W-1:0] allowed_0,
  input  logic [BYTE_W-1:0] allowed_1,
  input  logic [BYTE_W-1:0] allowed_2,
  input  logic [BYTE_W-1:0] allowed_3,
  input  logic [BYTE_W-1:0] requested_periph,
  input  logic [BYTE_W-1:0] command_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic              access_ok,
  output logic              force_speed,
  output logic [BYTE_W-1:0] speed_value
);

  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic [BYTE_W-1:0] allowed [PERIPH_MAX];

  assign allowed[0] = allowed_0;
  assign allowed[1] = allowed_1;
  assign allowed[2] = allowed_2;
  assign allowed[3] = allowed_3;

  tpag_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  tpag_dp #(
    .TASK_SLOTS  (TASK_SLOTS),
    .PERIPH_SLOTS(PERIPH_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mode            (mode),
    .task_id         (task_id),
    .periph_count    (periph_count),
    .allowed         (allowed),
    .requested_periph(requested_periph),
    .command_code    (command_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .access_ok       (access_ok),
    .force_speed     (force_speed),
    .speed_value     (speed_value)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready still high after an accepted beat");

  a_ready_with_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result beat appeared without reopening the input");

  a_drop_needs_accept: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("in_ready dropped without an accepted beat");
`endif

endmodule

@@ dv/task_peripheral_actuation_guard_test.sv @@
// Randomized self-checking bench for the actuation guard: a task-table predictor scores every result beat.
module task_peripheral_actuation_guard_test import tpag_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 8;
  localparam int ID_POOL     = 12;
  localparam int PERIPH_POOL = 6;

  typedef struct packed {
    mode_t                              op;
    logic [ID_W-1:0]                    id;
    logic [CNT_W-1:0]                   count;
    logic [PERIPH_MAX-1:0][BYTE_W-1:0]  allow;
    logic [BYTE_W-1:0]                  periph;
    logic [BYTE_W-1:0]                  cmd;
  } request_t;

  typedef struct packed {
    status_t           status;
    logic              ok;
    logic              forced;
    logic [BYTE_W-1:0] speed;
  } verdict_t;

  class access_ledger;
    bit                slot_used   [TABLE_DEPTH];
    logic [ID_W-1:0]   slot_id     [TABLE_DEPTH];
    int                slot_len    [TABLE_DEPTH];
    logic [BYTE_W-1:0] slot_periph [TABLE_DEPTH][PERIPH_MAX];
    int                actuations  [TABLE_DEPTH][PERIPH_MAX];
    bit                table_live;
    logic [BYTE_W-1:0] act_limit = MAX_ACT_RST;
    logic [BYTE_W-1:0] left_op   = LEFT_OP_RST;
    logic [BYTE_W-1:0] right_op  = RIGHT_OP_RST;
    logic [BYTE_W-1:0] safe_spd  = SAFE_SPEED_RST;
    verdict_t          pending_verdicts[$];
    int mismatches, beats_compared, grants, forced_grants, full_refusals, early_refusals;

    function void set_reg(cfg_idx_t idx, logic [BYTE_W-1:0] v);
      case (idx)
        CFG_MAX_ACT:    act_limit = v;
        CFG_LEFT_OP:    left_op   = v;
        CFG_RIGHT_OP:   right_op  = v;
        CFG_SAFE_SPEED: safe_spd  = v;
      endcase
    endfunction

    function int slot_of(logic [ID_W-1:0] id);
      for (int s = 0; s < TABLE_DEPTH; s++)
        if (slot_used[s] && slot_id[s] == id) return s;
      return -1;
    endfunction

    function void note_request(request_t r);
      verdict_t v;
      int       s;
      int       c;
      v.status = STAT_OK;
      v.ok     = 1'b0;
      v.forced = 1'b0;
      v.speed  = '0;
      s = slot_of(r.id);
      if (r.op == MODE_ADD) begin
        if (s < 0) begin
          for (int j = 0; j < TABLE_DEPTH; j++)
            if (!slot_used[j]) begin
              s = j;
              break;
            end
        end
        if (s < 0) begin
          v.status = STAT_FULL;
          full_refusals++;
        end else begin
          slot_used[s] = 1'b1;
          slot_id[s]   = r.id;
          slot_len[s]  = (r.count > PERIPH_MAX) ? PERIPH_MAX : int'(r.count);
          for (int j = 0; j < PERIPH_MAX; j++) begin
            slot_periph[s][j] = r.allow[j];
            actuations[s][j]  = 0;
          end
          table_live = 1'b1;
        end
      end else if (!table_live) begin
        v.status = STAT_UNINIT;
        early_refusals++;
      end else if (s >= 0) begin
        case (r.op)
          MODE_REMOVE: slot_used[s] = 1'b0;
          MODE_DONE: begin
            for (int j = 0; j < slot_len[s]; j++) actuations[s][j] = 0;
          end
          default: begin
            for (int j = 0; j < slot_len[s]; j++)
              if (slot_periph[s][j] == r.periph) begin
                c = actuations[s][j];
                if (c < 255) c++;
                actuations[s][j] = c;
                if (c <= int'(act_limit)) begin
                  v.ok = 1'b1;
                end else if (c == int'(act_limit) + 1 &&
                             (r.cmd == left_op || r.cmd == right_op)) begin
                  v.ok     = 1'b1;
                  v.forced = 1'b1;
                  v.speed  = safe_spd;
                end
                break;
              end
          end
        endcase
      end
      grants        += v.ok;
      forced_grants += v.forced;
      pending_verdicts.push_back(v);
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      beats_compared++;
      if (pending_verdicts.size() == 0) begin
        $error("result beat with no request outstanding");
        mismatches++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.ok !== want.ok) begin
        $error("access_ok: expected %0d, got %0d", want.ok, got.ok);
        mismatches++;
      end
      if (got.forced !== want.forced) begin
        $error("force_speed: expected %0d, got %0d", want.forced, got.forced);
        mismatches++;
      end
      if (got.speed !== want.speed) begin
        $error("speed_value: expected %0d, got %0d", want.speed, got.speed);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [BYTE_W-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        mode;
  logic [ID_W-1:0]   task_id;
  logic [CNT_W-1:0]  periph_count;
  logic [BYTE_W-1:0] allowed_0, allowed_1, allowed_2, allowed_3;
  logic [BYTE_W-1:0] requested_periph;
  logic [BYTE_W-1:0] command_code;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        status;
  logic              access_ok;
  logic              force_speed;
  logic [BYTE_W-1:0] speed_value;

  access_ledger      ledger = new;
  logic              hold_off_req = 1'b0;
  int                burst_left;
  int                items_offered;
  logic [ID_W-1:0]   id_pool     [ID_POOL];
  logic [BYTE_W-1:0] periph_pool [PERIPH_POOL];

  task_peripheral_actuation_guard u_dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      ledger.note_request('{op: mode_t'(mode), id: task_id, count: periph_count,
                            allow: {allowed_3, allowed_2, allowed_1, allowed_0},
                            periph: requested_periph, cmd: command_code});
    if (!rst && out_valid && out_ready)
      ledger.check_verdict('{status: status_t'(status), ok: access_ok,
                             forced: force_speed, speed: speed_value});
  end

  // receiver: randomly chosen stall styles, each held for a random span; one long hold on request
  initial begin
    int   style;
    int   span;
    int   hold_left;
    logic nxt;
    out_ready <= 1'b0;
    span      = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req && hold_left == 0) begin
        hold_left = 400;
        hold_off_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else begin
        if (span == 0) begin
          style = $urandom_range(0, 3);
          span  = $urandom_range(8, 80);
        end
        span--;
        case (style)
          0:       nxt = 1'b1;
          1:       nxt = 1'($urandom_range(0, 1));
          2:       nxt = ($urandom_range(0, 4) == 0);
          default: nxt = (span % 3 != 0);
        endcase
      end
      out_ready <= nxt;
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic request_t mk(mode_t op, logic [ID_W-1:0] id, logic [CNT_W-1:0] n,
                                  logic [BYTE_W-1:0] a0, a1, a2, a3, p, cmd);
    request_t r;
    r.op     = op;
    r.id     = id;
    r.count  = n;
    r.allow  = {a3, a2, a1, a0};
    r.periph = p;
    r.cmd    = cmd;
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_periph();
    return ($urandom_range(0, 7) == 0) ? BYTE_W'($urandom)
                                        : periph_pool[$urandom_range(0, PERIPH_POOL-1)];
  endfunction

  function automatic request_t pick_request();
    request_t r;
    int       roll;
    roll = $urandom_range(0, 99);
    if (roll < 18)      r.op = MODE_ADD;
    else if (roll < 26) r.op = MODE_REMOVE;
    else if (roll < 36) r.op = MODE_DONE;
    else                r.op = MODE_CHECK;
    // unknown ids only on non-add requests, so the pool alone can fill the table
    r.id = (r.op == MODE_ADD || $urandom_range(0, 9) != 0) ?
           id_pool[$urandom_range(0, ID_POOL-1)] : ID_W'($urandom);
    r.count = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(5, 7))
                                           : CNT_W'($urandom_range(0, 4));
    for (int j = 0; j < PERIPH_MAX; j++) r.allow[j] = pick_periph();
    r.periph = pick_periph();
    roll = $urandom_range(0, 99);
    r.cmd = (roll < 30) ? ledger.left_op : (roll < 60) ? ledger.right_op : BYTE_W'($urandom);
    return r;
  endfunction

  task automatic offer(request_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    mode             <= r.op;
    task_id          <= r.id;
    periph_count     <= r.count;
    allowed_0        <= r.allow[0];
    allowed_1        <= r.allow[1];
    allowed_2        <= r.allow[2];
    allowed_3        <= r.allow[3];
    requested_periph <= r.periph;
    command_code     <= r.cmd;
    in_valid         <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_offered++;
  endtask

  task automatic await_verdicts();
    in_valid <= 1'b0;
    do @(posedge clk); while (ledger.pending_verdicts.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [BYTE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    ledger.set_reg(idx, v);
  endtask

  task automatic apply_settings(logic [BYTE_W-1:0] lim, lop, rop, spd);
    write_reg(CFG_MAX_ACT, lim);
    write_reg(CFG_LEFT_OP, lop);
    write_reg(CFG_RIGHT_OP, rop);
    write_reg(CFG_SAFE_SPEED, spd);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) offer(pick_request());
  endtask

  // empty the table, then drive one counter through the limit into saturation
  task automatic saturate_counter();
    logic [BYTE_W-1:0] p;
    logic [BYTE_W-1:0] q;
    logic [BYTE_W-1:0] cmd;
    logic [ID_W-1:0]   tid;
    p   = periph_pool[$urandom_range(0, PERIPH_POOL-1)];
    q   = p ^ 8'h01;
    tid = id_pool[$urandom_range(0, ID_POOL-1)];
    for (int k = 0; k < ID_POOL; k++) offer(mk(MODE_REMOVE, id_pool[k], 0, 0, 0, 0, 0, 0, 0));
    offer(mk(MODE_ADD, tid, 4, p, p, q, p, 0, 0));
    for (int i = 0; i < 262; i++) begin
      case (i % 3)
        0:       cmd = BYTE_W'($urandom);
        1:       cmd = ledger.left_op;
        default: cmd = ledger.right_op;
      endcase
      offer(mk(MODE_CHECK, tid, 0, 0, 0, 0, 0, p, cmd));
    end
  endtask

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_MAX_ACT;
    cfg_wdata        <= '0;
    in_valid         <= 1'b0;
    mode             <= MODE_ADD;
    task_id          <= '0;
    periph_count     <= '0;
    allowed_0        <= '0;
    allowed_1        <= '0;
    allowed_2        <= '0;
    allowed_3        <= '0;
    requested_periph <= '0;
    command_code     <= '0;
    burst_left       = 0;
    items_offered    = 0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int k = 2; k < 9; k++) id_pool[k] = k - 1;
    for (int k = 9; k < ID_POOL; k++) id_pool[k] = $urandom;
    periph_pool[0] = 8'h00;
    periph_pool[1] = 8'hff;
    periph_pool[2] = 8'h5a;
    periph_pool[3] = 8'ha5;
    periph_pool[4] = 8'h21;
    periph_pool[5] = BYTE_W'($urandom);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset register values; nothing added yet
    offer(mk(MODE_REMOVE, 5, 0, 0, 0, 0, 0, 0, 0));
    offer(mk(MODE_DONE, '1, 7, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    offer(mk(MODE_CHECK, 0, 0, 0, 0, 0, 0, 0, LEFT_OP_RST));
    offer(mk(MODE_ADD, 0, 7, 8'h00, 8'hff, 8'h5a, 8'h00, 0, 0));
    offer(mk(MODE_CHECK, 0, 0, 0, 0, 0, 0, 8'h00, 8'hff));
    offer(mk(MODE_CHECK, 0, 0, 0, 0, 0, 0, 8'hff, LEFT_OP_RST));
    offer(mk(MODE_CHECK, 0, 0, 0, 0, 0, 0, 8'ha5, LEFT_OP_RST));
    offer(mk(MODE_CHECK, '1, 0, 0, 0, 0, 0, 8'h00, RIGHT_OP_RST));
    offer(mk(MODE_ADD, '1, 0, 8'h11, 8'h11, 8'h11, 8'h11, 0, 0));
    offer(mk(MODE_CHECK, '1, 0, 0, 0, 0, 0, 8'h11, RIGHT_OP_RST));
    for (int i = 1; i < 7; i++)
      offer(mk(MODE_ADD, i, CNT_W'(i % 5), 8'h21, 8'h22, 8'h23, 8'h24, 0, 0));
    offer(mk(MODE_ADD, 7, 4, 8'h21, 8'h22, 8'h21, 8'hff, 0, 0));
    offer(mk(MODE_ADD, 0, 2, 8'h09, 8'h09, 8'h00, 8'h00, 0, 0));
    offer(mk(MODE_REMOVE, 3, 0, 0, 0, 0, 0, 0, 0));
    offer(mk(MODE_REMOVE, 3, 0, 0, 0, 0, 0, 0, 0));
    offer(mk(MODE_ADD, 7, 4, 8'h21, 8'h22, 8'h21, 8'hff, 0, 0));
    offer(mk(MODE_DONE, 32'hdead_beef, 0, 0, 0, 0, 0, 0, 0));
    offer(mk(MODE_DONE, 0, 0, 0, 0, 0, 0, 0, 0));
    await_verdicts();

    // zero limit: first over-limit beat per counter
    apply_settings(8'd0, 8'hff, 8'h00, 8'hff);
    offer(mk(MODE_CHECK, 7, 0, 0, 0, 0, 0, 8'h21, 8'hff));
    offer(mk(MODE_CHECK, 7, 0, 0, 0, 0, 0, 8'h21, 8'h00));
    offer(mk(MODE_DONE, 7, 0, 0, 0, 0, 0, 0, 0));
    offer(mk(MODE_CHECK, 7, 0, 0, 0, 0, 0, 8'h22, 8'h33));
    offer(mk(MODE_CHECK, 7, 0, 0, 0, 0, 0, 8'hff, 8'h00));
    run_random(300);
    await_verdicts();

    apply_settings(8'd253, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    hold_off_req <= 1'b1;
    saturate_counter();
    run_random(80);
    await_verdicts();

    apply_settings(BYTE_W'($urandom_range(1, 6)), 8'h00, 8'hff, BYTE_W'($urandom));
    run_random(200);
    await_verdicts();
    run_random(200);
    await_verdicts();

    begin
      logic [BYTE_W-1:0] shared_op;
      shared_op = BYTE_W'($urandom);
      apply_settings(8'd2, shared_op, shared_op, 8'h00);
    end
    run_random(350);
    await_verdicts();

    apply_settings(BYTE_W'($urandom_range(0, 253)), BYTE_W'($urandom), BYTE_W'($urandom),
                   BYTE_W'($urandom));
    run_random(350);
    await_verdicts();
    repeat (8) @(posedge clk);

    $display("%0d requests over six register settings, %0d result beats compared;",
             items_offered, ledger.beats_compared);
    $display("%0d granted (%0d at safe speed), %0d adds on a full table, %0d before any add.",
             ledger.grants, ledger.forced_grants, ledger.full_refusals, ledger.early_refusals);
    if (ledger.mismatches == 0 && ledger.pending_verdicts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
